@@ design/dcsr_pkg.sv @@
// Shared types, constants and codes of the dense-to-CSR stream encoder.
`default_nettype none

package dcsr_pkg;

    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_MAX_COLUMNS = 4096;

    localparam int WORD_W     = 32;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int COLUMN_W   = 12;
    localparam int ROW_W      = 12;
    localparam int COUNT_W    = 25;

    localparam logic [CFG_DATA_W-1:0] SHAPE_RESET = CFG_DATA_W'(1);
    localparam logic [COUNT_W-1:0]    COUNT_MAX   = {COUNT_W{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_ENTRY   = 1'b0,
        KIND_ROW_END = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic                nonzero;
        logic                row_end;
        logic                mat_end;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic [COUNT_W-1:0]  pointer;
    } item_t;

    typedef struct packed {
        result_kind_t        result_kind;
        logic [WORD_W-1:0]   entry_value;
        logic [COLUMN_W-1:0] entry_column;
        logic [ROW_W-1:0]    row_number;
        logic [COUNT_W-1:0]  row_pointer;
        logic                matrix_done;
        logic                last_of_run;
    } result_t;

endpackage

`default_nettype wire

@@ design/dcsr_if.sv @@
// Stream interfaces for the dense element input and the CSR result output.
`default_nettype none

interface dcsr_in_if;
    import dcsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] element_word;

    modport source (output valid, output element_word, input ready);
    modport sink (input valid, input element_word, output ready);
endinterface

interface dcsr_out_if;
    import dcsr_pkg::*;

    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [WORD_W-1:0]   entry_value;
    logic [COLUMN_W-1:0] entry_column;
    logic [ROW_W-1:0]    row_number;
    logic [COUNT_W-1:0]  row_pointer;
    logic                matrix_done;
    logic                last_of_run;

    modport source (
        output valid, output result_kind, output entry_value, output entry_column,
        output row_number, output row_pointer, output matrix_done, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input result_kind, input entry_value, input entry_column,
        input row_number, input row_pointer, input matrix_done, input last_of_run,
        output ready
    );
endinterface

`default_nettype wire

@@ design/dcsr_front.sv @@
// Front end: shape registers, position and nonzero counters, item classification.
`default_nettype none

module dcsr_front #(
    parameter int MAX_ROWS    = dcsr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = dcsr_pkg::DEF_MAX_COLUMNS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dcsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    dcsr_in_if.sink                          in_ch,
    input  logic                             q_ready,
    output logic                             q_push,
    output dcsr_pkg::item_t                  q_item
);
    import dcsr_pkg::*;

    localparam int RCW = ($clog2(MAX_ROWS) > 0) ? $clog2(MAX_ROWS) : 1;
    localparam int CCW = ($clog2(MAX_COLUMNS) > 0) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RXW = ((RCW + 1) > CFG_DATA_W) ? (RCW + 1) : CFG_DATA_W;
    localparam int CXW = ((CCW + 1) > CFG_DATA_W) ? (CCW + 1) : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] row_count_reg;
    logic [CFG_DATA_W-1:0] column_count_reg;
    logic [RCW-1:0]        row_counter_reg;
    logic [RCW-1:0]        row_counter_next;
    logic [CCW-1:0]        column_counter_reg;
    logic [CCW-1:0]        column_counter_next;
    logic [COUNT_W-1:0]    nonzero_counter_reg;
    logic [COUNT_W-1:0]    nonzero_counter_next;

    logic [RXW-1:0]     rows_x;
    logic [CXW-1:0]     cols_x;
    logic               accept;
    logic               nonzero;
    logic               row_last;
    logic               mat_last;
    logic [COUNT_W-1:0] pointer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= SHAPE_RESET;
            column_count_reg <= SHAPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (row_count_reg == '0)
            rows_x = RXW'(1);
        else if (RXW'(row_count_reg) > RXW'(MAX_ROWS))
            rows_x = RXW'(MAX_ROWS);
        else
            rows_x = RXW'(row_count_reg);

        if (column_count_reg == '0)
            cols_x = CXW'(1);
        else if (CXW'(column_count_reg) > CXW'(MAX_COLUMNS))
            cols_x = CXW'(MAX_COLUMNS);
        else
            cols_x = CXW'(column_count_reg);
    end

    assign in_ch.ready = q_ready;
    assign accept      = in_ch.valid && q_ready;
    assign nonzero     = |in_ch.element_word[WORD_W-2:0];
    assign row_last    = (CXW'(column_counter_reg) + CXW'(1)) >= cols_x;
    assign mat_last    = row_last && ((RXW'(row_counter_reg) + RXW'(1)) >= rows_x);

    always_comb
    begin
        pointer = nonzero_counter_reg;
        if (nonzero && (nonzero_counter_reg != COUNT_MAX))
            pointer = nonzero_counter_reg + COUNT_W'(1);

        column_counter_next  = column_counter_reg + CCW'(1);
        row_counter_next     = row_counter_reg;
        nonzero_counter_next = pointer;
        if (row_last)
        begin
            column_counter_next = '0;
            row_counter_next    = row_counter_reg + RCW'(1);
            if (mat_last)
            begin
                row_counter_next     = '0;
                nonzero_counter_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_counter_reg     <= '0;
            column_counter_reg  <= '0;
            nonzero_counter_reg <= '0;
        end
        else if (accept)
        begin
            row_counter_reg     <= row_counter_next;
            column_counter_reg  <= column_counter_next;
            nonzero_counter_reg <= nonzero_counter_next;
        end
    end

    assign q_push = accept && (nonzero || row_last);

    always_comb
    begin
        q_item.word    = in_ch.element_word;
        q_item.nonzero = nonzero;
        q_item.row_end = row_last;
        q_item.mat_end = mat_last;
        q_item.column  = COLUMN_W'(column_counter_reg);
        q_item.row     = ROW_W'(row_counter_reg);
        q_item.pointer = pointer;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && mat_last |=> (row_counter_reg == '0) && (nonzero_counter_reg == '0))
        else $error("counters not cleared after the final row");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !row_last |=> column_counter_reg == $past(column_counter_reg) + CCW'(1))
        else $error("column counter did not advance");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_item.nonzero || q_item.row_end)
        else $error("item queued that produces no result");

endmodule

`default_nettype wire

@@ design/dcsr_fifo.sv @@
// Short item queue between the front end and the result sequencer.
`default_nettype none

module dcsr_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dcsr_pkg::item_t push_item,
    output logic            ready,
    input  logic            pop,
    output logic            head_valid,
    output dcsr_pkg::item_t head_item
);
    import dcsr_pkg::*;

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign ready      = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("push into a full queue");

endmodule

`default_nettype wire

@@ design/dcsr_back.sv @@
// Result sequencer: expands each queued item into its entry and row-end results.
`default_nettype none

module dcsr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  dcsr_pkg::item_t head_item,
    output logic            pop,
    dcsr_out_if.source      out_ch
);
    import dcsr_pkg::*;

    logic    phase_reg;
    logic    phase_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    load;
    logic    emit_entry;

    assign load       = head_valid && (!out_valid_reg || out_ch.ready);
    assign emit_entry = head_item.nonzero && !phase_reg;

    always_comb
    begin
        res_next   = res_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            res_next.row_number  = head_item.row;
            res_next.row_pointer = head_item.pointer;
            if (emit_entry)
            begin
                res_next.result_kind  = KIND_ENTRY;
                res_next.entry_value  = head_item.word;
                res_next.entry_column = head_item.column;
                res_next.matrix_done  = 1'b0;
                res_next.last_of_run  = !head_item.row_end;
            end
            else
            begin
                res_next.result_kind  = KIND_ROW_END;
                res_next.entry_value  = '0;
                res_next.entry_column = '0;
                res_next.matrix_done  = head_item.mat_end;
                res_next.last_of_run  = 1'b1;
            end
            if (emit_entry && head_item.row_end)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_kind  = res_reg.result_kind;
    assign out_ch.entry_value  = res_reg.entry_value;
    assign out_ch.entry_column = res_reg.entry_column;
    assign out_ch.row_number   = res_reg.row_number;
    assign out_ch.row_pointer  = res_reg.row_pointer;
    assign out_ch.matrix_done  = res_reg.matrix_done;
    assign out_ch.last_of_run  = res_reg.last_of_run;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.matrix_done |-> res_reg.result_kind == KIND_ROW_END)
        else $error("matrix done on a result that is not a row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> head_valid && head_item.nonzero && head_item.row_end)
        else $error("row-end phase without a matching queued item");

    assert property (@(posedge clk) disable iff (!rst_n)
        load && emit_entry && head_item.row_end |=> phase_reg && out_valid_reg)
        else $error("row end did not follow its entry");

endmodule

`default_nettype wire

@@ design/dense_to_csr_stream_encoder.sv @@
// Top level of the dense-to-CSR stream encoder.
//
// The block takes a dense matrix one 32-bit float word per transfer on in_ch,
// in row-major order, and produces CSR results on out_ch. A nonzero word
// gives an entry result with its column; the last column of each row also
// gives a row-end result carrying the row's end pointer. The shape comes from
// the row_count and column_count registers, written through cfg_we, cfg_index
// and cfg_data; the user must do so only while the block is idle (unenforced).
// A front end classifies each word and updates the counters in the cycle of
// its transfer; a four-entry queue decouples it from the result sequencer.
// Each item goes through the queue slot and then the output register.
// The front end takes one word per cycle while the queue has room; the output
// port sends one result per cycle while the receiver is ready, so an item with
// both an entry and a row end gives two results in turn. When the receiver
// stalls, the output register holds its result and the queue absorbs up to
// four items before in_ch.ready drops. Reset clears the counters, empties the
// queue and sets both shape registers to one.
`default_nettype none

module dense_to_csr_stream_encoder #(
    parameter int MAX_ROWS    = dcsr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = dcsr_pkg::DEF_MAX_COLUMNS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dcsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    dcsr_in_if.sink                          in_ch,
    dcsr_out_if.source                       out_ch
);
    import dcsr_pkg::*;

    logic  q_ready;
    logic  q_push;
    item_t q_item;
    logic  q_pop;
    logic  head_valid;
    item_t head_item;

    dcsr_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    dcsr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    dcsr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
